// ===== rtl/variable_partition_allocator_core_assert.svh =====
// Assertion macros shared by the allocator RTL
`ifndef VARIABLE_PARTITION_ALLOCATOR_CORE_ASSERT_SVH
`define VARIABLE_PARTITION_ALLOCATOR_CORE_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define VPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Antecedent implies consequent in the next cycle
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== rtl/vpa_pkg.sv =====
// Types and constants of the variable partition allocator
`timescale 1ns / 1ps
`default_nettype none

package vpa_pkg;

    localparam int DEF_MAX_REQUESTS = 64;
    localparam int DEF_MAX_SEGMENTS = 65;
    localparam int DEF_ADDR_BITS    = 16;

    localparam int SIZE_W = 16;
    localparam int ID_W   = 6;

    localparam logic [SIZE_W-1:0] POOL_RESET = 16'd1024;

    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_POOL_SIZE  = 1'b1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   req_id;
        logic [SIZE_W-1:0] req_size;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              granted;
        logic [SIZE_W-1:0] base_address;
        logic [SIZE_W-1:0] total_free;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/variable_partition_allocator_core.sv =====
// Variable partition allocator: first/best fit over an address ordered free table
//
// Channel  Dir  Handshake           Payload
// in       in   i_in_valid/o_in_stall  t_in_item  {mode, req_id, req_size}
// out      out  o_out_valid/i_out_stall t_out_item {status, granted, base_address, total_free}
// cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// An item scans the table in address order; an item rejected at once goes straight to its
// result. Removing or inserting a segment shifts the entries behind it, one by one.
// The free table is one memory with one read and one write port; one entry per cycle.
// After reset and after a pool_size write, the init state writes the first segment unless the pool is 0.
// Input stalls until the result sits in the output register, and while i_cfg_valid is high.
`timescale 1ns / 1ps
`default_nettype none

`include "variable_partition_allocator_core_assert.svh"

module variable_partition_allocator_core
    import vpa_pkg::*;
#(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_in_item          i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_out_item              o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    localparam int REQ_IW = $clog2(MAX_REQUESTS);
    localparam int SEG_IW = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam logic [SIZE_W-1:0] BASE_MASK =
        (ADDR_BITS >= SIZE_W) ? {SIZE_W{1'b1}} : SIZE_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);

    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_SCAN = 8'b0000_0100,
        S_ACT  = 8'b0000_1000,
        S_FACT = 8'b0001_0000,
        S_SHDN = 8'b0010_0000,
        S_SHUP = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state;

    logic              r_policy;
    logic [SIZE_W-1:0] r_pool;
    logic [SIZE_W-1:0] r_free;
    logic [CNT_W-1:0]  r_count;
    logic [MAX_REQUESTS-1:0] r_granted;

    logic [SIZE_W-1:0] seg_start_mem [MAX_SEGMENTS];
    logic [SIZE_W-1:0] seg_len_mem   [MAX_SEGMENTS];
    logic [SIZE_W-1:0] rec_base_mem  [MAX_REQUESTS];
    logic [SIZE_W-1:0] rec_len_mem   [MAX_REQUESTS];

    logic [SIZE_W-1:0] r_rd_start, r_rd_len, r_rec_base, r_rec_len;

    logic              r_mode;
    logic [REQ_IW-1:0] r_id;
    logic [SIZE_W-1:0] r_size;
    logic [CNT_W-1:0]  r_idx;
    logic              r_dv;
    logic [SEG_IW-1:0] r_didx;
    logic              r_wv;
    logic [SEG_IW-1:0] r_waddr;
    logic              r_found;
    logic [SEG_IW-1:0] r_pick;
    logic [SIZE_W-1:0] r_pick_start, r_pick_len;
    logic              r_has_lo, r_has_hi;
    logic [SIZE_W-1:0] r_lo_start, r_lo_len, r_hi_start, r_hi_len;
    logic [CNT_W-1:0]  r_pos;
    logic [1:0]        r_status;
    logic [SIZE_W-1:0] r_base;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [31:0]       in_id_ext;
    logic [REQ_IW-1:0] in_idx;
    logic              in_id_ok;
    logic              in_acc;
    logic              cfg_acc;
    logic              out_free;
    logic [SEG_IW-1:0] rd_addr;
    logic              seg_we;
    logic [SEG_IW-1:0] seg_wa;
    logic [SIZE_W-1:0] seg_wd_start, seg_wd_len;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  pos_m1;
    logic [SIZE_W:0]   lo_end, blk_end;
    logic              join_lo, join_hi;
    logic [SIZE_W-1:0] new_len;

    assign in_id_ext = 32'(i_in.req_id);
    assign in_idx    = in_id_ext[REQ_IW-1:0];
    assign in_id_ok  = in_id_ext < 32'(MAX_REQUESTS);
    assign in_acc    = i_in_valid && !o_in_stall;
    assign cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign idx_m1  = r_idx - 1'b1;
    assign pos_m1  = r_pos - 1'b1;
    assign lo_end  = {1'b0, r_lo_start} + {1'b0, r_lo_len};
    assign blk_end = {1'b0, r_rec_base} + {1'b0, r_rec_len};
    assign join_lo = r_has_lo && (lo_end == {1'b0, r_rec_base});
    assign join_hi = r_has_hi && (blk_end == {1'b0, r_hi_start});
    assign new_len = r_pick_len - r_size;

    always_comb begin
        rd_addr = r_idx[SEG_IW-1:0];
        if (r_state == S_SHUP) begin
            rd_addr = idx_m1[SEG_IW-1:0];
        end
        seg_we       = 1'b0;
        seg_wa       = r_waddr;
        seg_wd_start = r_rd_start;
        seg_wd_len   = r_rd_len;
        if (r_wv) begin
            seg_we = 1'b1;
        end else begin
            case (r_state)
                S_INIT: begin
                    seg_we       = (r_pool != '0);
                    seg_wa       = '0;
                    seg_wd_start = '0;
                    seg_wd_len   = r_pool;
                end
                S_ACT: begin
                    seg_we       = r_found && (new_len != '0);
                    seg_wa       = r_pick;
                    seg_wd_start = r_pick_start + r_size;
                    seg_wd_len   = new_len;
                end
                S_FACT: begin
                    seg_we = join_lo || join_hi;
                    if (join_lo) begin
                        seg_wa       = pos_m1[SEG_IW-1:0];
                        seg_wd_start = r_lo_start;
                        seg_wd_len   = join_hi ? (r_lo_len + r_rec_len + r_hi_len)
                                               : (r_lo_len + r_rec_len);
                    end else begin
                        seg_wa       = r_pos[SEG_IW-1:0];
                        seg_wd_start = r_rec_base;
                        seg_wd_len   = r_hi_len + r_rec_len;
                    end
                end
                S_SHUP: begin
                    seg_we       = (r_idx == r_pos);
                    seg_wa       = r_pos[SEG_IW-1:0];
                    seg_wd_start = r_rec_base;
                    seg_wd_len   = r_rec_len;
                end
                default: begin
                    seg_we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (seg_we) begin
            seg_start_mem[seg_wa] <= seg_wd_start;
            seg_len_mem[seg_wa]   <= seg_wd_len;
        end
        r_rd_start <= seg_start_mem[rd_addr];
        r_rd_len   <= seg_len_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ACT && r_found) begin
            rec_base_mem[r_id] <= r_pick_start;
            rec_len_mem[r_id]  <= r_size;
        end
        r_rec_base <= rec_base_mem[(r_state == S_IDLE) ? in_idx : r_id];
        r_rec_len  <= rec_len_mem[(r_state == S_IDLE) ? in_idx : r_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_policy    <= 1'b0;
            r_pool      <= POOL_RESET;
            r_free      <= POOL_RESET;
            r_count     <= '0;
            r_granted   <= '0;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_wv <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_count   <= (r_pool != '0) ? CNT_W'(1) : '0;
                    r_free    <= r_pool;
                    r_granted <= '0;
                    r_state   <= S_IDLE;
                end
                S_IDLE: begin
                    if (cfg_acc) begin
                        if (i_cfg_index == REG_FIT_POLICY) begin
                            r_policy <= i_cfg_data[0];
                        end else begin
                            r_pool  <= i_cfg_data;
                            r_state <= S_INIT;
                        end
                    end else if (in_acc) begin
                        r_mode   <= i_in.mode;
                        r_id     <= in_idx;
                        r_size   <= i_in.req_size;
                        r_idx    <= '0;
                        r_dv     <= 1'b0;
                        r_found  <= 1'b0;
                        r_has_lo <= 1'b0;
                        r_has_hi <= 1'b0;
                        r_base   <= '0;
                        if (i_in.mode == MODE_ALLOC) begin
                            if (!in_id_ok || i_in.req_size == '0 || r_granted[in_idx]) begin
                                r_status <= ST_NO_FIT;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else begin
                            if (!in_id_ok || !r_granted[in_idx]) begin
                                r_status <= ST_IGNORED;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < r_count) begin
                        r_dv   <= 1'b1;
                        r_didx <= r_idx[SEG_IW-1:0];
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_mode == MODE_ALLOC) begin
                        if (r_dv && r_rd_len >= r_size
                                && (!r_found || (r_policy && r_rd_len < r_pick_len))) begin
                            r_found      <= 1'b1;
                            r_pick       <= r_didx;
                            r_pick_start <= r_rd_start;
                            r_pick_len   <= r_rd_len;
                        end
                        if ((r_dv && r_rd_len >= r_size && !r_policy)
                                || (!r_dv && r_idx >= r_count)) begin
                            r_state <= S_ACT;
                        end
                    end else begin
                        if (r_dv && r_rd_start > r_rec_base) begin
                            r_has_hi   <= 1'b1;
                            r_hi_start <= r_rd_start;
                            r_hi_len   <= r_rd_len;
                            r_pos      <= CNT_W'(r_didx);
                            r_state    <= S_FACT;
                        end else if (r_dv) begin
                            r_has_lo   <= 1'b1;
                            r_lo_start <= r_rd_start;
                            r_lo_len   <= r_rd_len;
                        end else if (r_idx >= r_count) begin
                            r_pos   <= r_count;
                            r_state <= S_FACT;
                        end
                    end
                end
                S_ACT: begin
                    if (!r_found) begin
                        r_status <= ST_NO_FIT;
                        r_state  <= S_DONE;
                    end else begin
                        r_status         <= ST_ALLOCATED;
                        r_base           <= r_pick_start;
                        r_free           <= r_free - r_size;
                        r_granted[r_id]  <= 1'b1;
                        if (new_len == '0) begin
                            r_idx   <= CNT_W'(r_pick) + 1'b1;
                            r_state <= S_SHDN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_FACT: begin
                    r_status        <= ST_FREED;
                    r_free          <= r_free + r_rec_len;
                    r_granted[r_id] <= 1'b0;
                    if (join_lo && join_hi) begin
                        r_idx   <= r_pos + 1'b1;
                        r_state <= S_SHDN;
                    end else if (join_lo || join_hi) begin
                        r_state <= S_DONE;
                    end else if (r_count < SEG_MAX) begin
                        r_idx   <= r_count;
                        r_state <= S_SHUP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SHDN: begin
                    if (r_idx < r_count) begin
                        r_wv    <= 1'b1;
                        r_waddr <= idx_m1[SEG_IW-1:0];
                        r_idx   <= r_idx + 1'b1;
                    end else if (!r_wv) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_SHUP: begin
                    if (r_idx > r_pos) begin
                        r_wv    <= 1'b1;
                        r_waddr <= r_idx[SEG_IW-1:0];
                        r_idx   <= idx_m1;
                    end else if (!r_wv) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out.status       <= r_status;
            r_out.granted      <= (r_status == ST_ALLOCATED);
            r_out.base_address <= (r_status == ST_ALLOCATED) ? (r_base & BASE_MASK) : '0;
            r_out.total_free   <= r_free;
        end
    end

    `VPA_ASSERT_SAME(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= SEG_MAX)
    `VPA_ASSERT_SAME(a_free_le_pool, i_clk, i_rst_n, r_state == S_IDLE, r_free <= r_pool)
    `VPA_ASSERT_SAME(a_grant_status, i_clk, i_rst_n, r_out_valid && r_out.granted,
        r_out.status == ST_ALLOCATED)
    `VPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)

endmodule

`default_nettype wire
